@@ design/opp_pkg.sv @@
`default_nettype none

package opp_pkg;

    localparam int MAX_TERMINALS_DEF = 16;
    localparam int STACK_DEPTH_DEF   = 64;

    localparam logic [7:0] END_MARK   = 8'h24;
    localparam logic [7:0] YIELD_MARK = 8'h3C;
    localparam logic [7:0] EQUAL_MARK = 8'h3D;
    localparam logic [5:0] RED_MAX    = 6'd63;

    typedef enum logic [1:0] {
        FUNC_TERM  = 2'd0,
        FUNC_REL   = 2'd1,
        FUNC_PARSE = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_YIELD = 2'd1,
        REL_EQUAL = 2'd2,
        REL_TAKES = 2'd3
    } rel_t;

    typedef enum logic [2:0] {
        ST_SHIFT    = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_INVALID  = 3'd2,
        ST_REJECT   = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_LOADED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] row_index;
        logic [3:0] col_index;
        logic [7:0] char_value;
        logic [1:0] relation;
    } in_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] reductions;
        logic [6:0] stack_level;
    } out_t;

    typedef struct packed {
        logic    accept;
        logic    clr_wr;
        logic    lookup;
        logic    push1;
        logic    push2;
        logic    pop;
        logic    load_top;
        logic    red_inc;
        logic    emit;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic       is_accept;
        logic       si_ok;
        logic       ii_ok;
        logic [1:0] rel;
        logic       top_zero;
        logic       top_yield;
        logic       overflow;
        logic       clr_done;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ design/operator_precedence_parser.sv @@
`default_nettype none

// channel   direction  handshake            beat
// in        input      in_valid / in_stall   opp_pkg::in_t  (func, indexes, char, relation)
// out       output     out_valid / out_stall opp_pkg::out_t (status, reductions, stack_level)
// cfg       input      cfg_write             cfg_data, term_count
//
// load and no-op beats: if the output register is free, result valid the cycle after the in
//   beat, in_stall stays low; else the beat waits in S_FIN with in_stall high
// parse beats: a shift runs S_LOOK, S_RD, S_DEC, S_PUSH2, S_FIN; each reduction pops entries
//   via S_POP/S_POPW, the marker via S_POPY, then looks up anew: a one-port stack read loop
// reset: relation table cleared one entry a cycle, all MAX_TERMINALS*MAX_TERMINALS entries
//   with in_stall high; cfg writes are taken during that pass
// a stalled result waits in the output register; the next in beat is still taken

module operator_precedence_parser #(
    parameter int MAX_TERMINALS = opp_pkg::MAX_TERMINALS_DEF,
    parameter int STACK_DEPTH   = opp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire opp_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output opp_pkg::out_t     out_data,
    input  wire logic         cfg_write,
    input  wire logic [4:0]   cfg_data
);

    import opp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    opp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    opp_datapath #(
        .MAX_TERMINALS (MAX_TERMINALS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ design/opp_ram.sv @@
`default_nettype none

module opp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ design/opp_datapath.sv @@
`default_nettype none

module opp_datapath #(
    parameter int MAX_TERMINALS = 16,
    parameter int STACK_DEPTH   = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire opp_pkg::in_t  in_data,
    input  wire logic          cfg_write,
    input  wire logic [4:0]    cfg_data,
    input  wire opp_pkg::cmd_t cmd,
    output opp_pkg::stat_t     stat,
    output logic               out_valid,
    input  wire logic          out_stall,
    output opp_pkg::out_t      out_data
);

    import opp_pkg::*;

    localparam int TW  = $clog2(MAX_TERMINALS);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int RN  = MAX_TERMINALS * MAX_TERMINALS;
    localparam int RAW = $clog2(RN);

    logic [4:0]     term_count_reg;
    logic [7:0]     term_chars_reg [MAX_TERMINALS];
    logic [7:0]     ch_reg;
    logic [TW-1:0]  si_reg;
    logic [TW-1:0]  ii_reg;
    logic           si_ok_reg;
    logic           ii_ok_reg;
    logic [SW-1:0]  top_reg;
    logic [7:0]     top_char_reg;
    logic [5:0]     red_reg;
    logic [RAW-1:0] clr_cnt_reg;
    logic           out_valid_reg;
    out_t           out_data_reg;

    logic [TW-1:0]  si_idx;
    logic [TW-1:0]  ii_idx;
    logic           si_hit;
    logic           ii_hit;
    logic           out_free;
    logic           clr_stk;
    logic           row_ok;
    logic           col_ok;
    logic [SW:0]    level_wide;

    logic           st_we;
    logic [SW-1:0]  st_waddr;
    logic [7:0]     st_wdata;
    logic [SW-1:0]  st_raddr;
    logic [7:0]     st_rdata;

    logic           rl_we;
    logic [RAW-1:0] rl_waddr;
    logic [1:0]     rl_wdata;
    logic [RAW-1:0] rl_raddr;
    logic [1:0]     rl_rdata;

    assign row_ok   = int'(in_data.row_index) < MAX_TERMINALS;
    assign col_ok   = int'(in_data.col_index) < MAX_TERMINALS;
    assign out_free = !out_valid_reg || !out_stall;
    assign clr_stk  = cmd.emit && (cmd.status != ST_SHIFT) && (cmd.status != ST_LOADED);

    // highest matching index below term_count wins
    always_comb
    begin
        si_hit = 1'b0;
        ii_hit = 1'b0;
        si_idx = '0;
        ii_idx = '0;
        for (int k = 0; k < MAX_TERMINALS; k++)
        begin
            if (k < int'(term_count_reg))
            begin
                if (term_chars_reg[k] == top_char_reg)
                begin
                    si_hit = 1'b1;
                    si_idx = TW'(k);
                end
                if (term_chars_reg[k] == ch_reg)
                begin
                    ii_hit = 1'b1;
                    ii_idx = TW'(k);
                end
            end
        end
    end

    always_comb
    begin
        st_we    = cmd.push1 || cmd.push2;
        st_waddr = cmd.push2 ? SW'(top_reg + SW'(2)) : SW'(top_reg + SW'(1));
        st_wdata = cmd.push2 ? ch_reg
                 : ((rel_t'(rl_rdata) == REL_YIELD) ? YIELD_MARK : EQUAL_MARK);
    end

    assign st_raddr = SW'(top_reg - SW'(1));

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            rl_we    = 1'b1;
            rl_waddr = clr_cnt_reg;
            rl_wdata = REL_NONE;
        end
        else
        begin
            rl_we    = cmd.accept && (in_data.func == FUNC_REL) && row_ok && col_ok;
            rl_waddr = RAW'(int'(in_data.row_index) * MAX_TERMINALS
                            + int'(in_data.col_index));
            rl_wdata = in_data.relation;
        end
    end

    assign rl_raddr = RAW'(int'(si_reg) * MAX_TERMINALS + int'(ii_reg));

    opp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    opp_ram #(
        .WIDTH (2),
        .DEPTH (RN)
    ) u_rel_ram (
        .clk   (clk),
        .we    (rl_we),
        .waddr (rl_waddr),
        .wdata (rl_wdata),
        .raddr (rl_raddr),
        .rdata (rl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
            for (int k = 0; k < MAX_TERMINALS; k++)
            begin
                term_chars_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                term_count_reg <= cfg_data;
            end
            if (cmd.accept && (in_data.func == FUNC_TERM) && row_ok)
            begin
                term_chars_reg[TW'(in_data.row_index)] <= in_data.char_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            top_char_reg  <= END_MARK;
            red_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= RAW'(clr_cnt_reg + RAW'(1));
            end

            if (clr_stk)
            begin
                top_reg      <= '0;
                top_char_reg <= END_MARK;
            end
            else if (cmd.push2)
            begin
                top_reg      <= SW'(top_reg + SW'(2));
                top_char_reg <= ch_reg;
            end
            else if (cmd.pop)
            begin
                top_reg <= SW'(top_reg - SW'(1));
            end
            else if (cmd.load_top)
            begin
                // the bottom entry is never written; the end marker is used for it in place of the RAM data
                top_char_reg <= (top_reg == '0) ? END_MARK : st_rdata;
            end

            if (cmd.accept)
            begin
                red_reg <= '0;
            end
            else if (cmd.red_inc && (red_reg != RED_MAX))
            begin
                red_reg <= red_reg + 6'd1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign level_wide = clr_stk ? (SW+1)'(1) : (SW+1)'({1'b0, top_reg} + (SW+1)'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg <= in_data.char_value;
        end
        if (cmd.lookup)
        begin
            si_reg    <= si_idx;
            ii_reg    <= ii_idx;
            si_ok_reg <= si_hit;
            ii_ok_reg <= ii_hit;
        end
        if (cmd.emit)
        begin
            out_data_reg.status      <= cmd.status;
            out_data_reg.reductions  <= (cmd.status == ST_LOADED) ? 6'd0 : red_reg;
            out_data_reg.stack_level <= 7'(level_wide);
        end
    end

    always_comb
    begin
        stat.is_accept = (top_char_reg == END_MARK) && (ch_reg == END_MARK);
        stat.si_ok     = si_ok_reg;
        stat.ii_ok     = ii_ok_reg;
        stat.rel       = rl_rdata;
        stat.top_zero  = (top_reg == '0);
        stat.top_yield = (top_char_reg == YIELD_MARK);
        stat.overflow  = (int'(top_reg) + 2) > (STACK_DEPTH - 1);
        stat.clr_done  = (clr_cnt_reg == RAW'(RN - 1));
        stat.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result beat loaded while output register is occupied");

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        clr_stk |=> (top_reg == '0) && (top_char_reg == END_MARK))
        else $error("stack not returned to end marker after a final status");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push2 && !clr_stk) |=> (top_char_reg == $past(ch_reg)))
        else $error("top character does not follow the shifted symbol");

    a_red_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (red_reg == RED_MAX && !cmd.accept) |=> (red_reg == RED_MAX))
        else $error("reduction count wrapped");

endmodule

`default_nettype wire

@@ design/opp_ctrl.sv @@
`default_nettype none

module opp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [1:0]     in_func,
    output logic                in_stall,
    input  wire opp_pkg::stat_t stat,
    output opp_pkg::cmd_t       cmd
);

    import opp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_RD,
        S_DEC,
        S_PUSH2,
        S_POP,
        S_POPW,
        S_POPY,
        S_FIN
    } state_t;

    state_t  state_reg;
    status_t fin_status_reg;
    rel_t    rel;

    assign rel      = rel_t'(stat.rel);
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            fin_status_reg <= ST_LOADED;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (stat.clr_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_func == FUNC_PARSE)
                        begin
                            state_reg <= S_LOOK;
                        end
                        else if (!stat.out_free)
                        begin
                            state_reg      <= S_FIN;
                            fin_status_reg <= ST_LOADED;
                        end
                    end
                end
                S_LOOK:
                begin
                    if (stat.is_accept)
                    begin
                        state_reg      <= S_FIN;
                        fin_status_reg <= ST_ACCEPT;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (!(stat.si_ok && stat.ii_ok))
                    begin
                        state_reg      <= S_FIN;
                        fin_status_reg <= ST_INVALID;
                    end
                    else
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    unique case (rel)
                        REL_YIELD, REL_EQUAL:
                        begin
                            if (stat.overflow)
                            begin
                                state_reg      <= S_FIN;
                                fin_status_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                state_reg <= S_PUSH2;
                            end
                        end
                        REL_TAKES:
                        begin
                            if (stat.top_zero)
                            begin
                                state_reg      <= S_FIN;
                                fin_status_reg <= ST_REJECT;
                            end
                            else
                            begin
                                state_reg <= S_POP;
                            end
                        end
                        REL_NONE:
                        begin
                            state_reg      <= S_FIN;
                            fin_status_reg <= ST_REJECT;
                        end
                    endcase
                end
                S_PUSH2:
                begin
                    state_reg      <= S_FIN;
                    fin_status_reg <= ST_SHIFT;
                end
                S_POP:
                begin
                    priority if (!stat.top_zero && !stat.top_yield)
                    begin
                        state_reg <= S_POPW;
                    end
                    else if (!stat.top_zero)
                    begin
                        state_reg <= S_POPY;
                    end
                    else
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_POPW:
                begin
                    state_reg <= S_POP;
                end
                S_POPY:
                begin
                    state_reg <= S_LOOK;
                end
                S_FIN:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = fin_status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && (in_func != FUNC_PARSE) && stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_LOADED;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
            end
            S_RD:
            begin
            end
            S_DEC:
            begin
                cmd.push1 = ((rel == REL_YIELD) || (rel == REL_EQUAL)) && !stat.overflow;
            end
            S_PUSH2:
            begin
                cmd.push2 = 1'b1;
            end
            S_POP:
            begin
                cmd.pop     = !stat.top_zero;
                cmd.red_inc = stat.top_zero;
            end
            S_POPW:
            begin
                cmd.load_top = 1'b1;
            end
            S_POPY:
            begin
                cmd.load_top = 1'b1;
                cmd.red_inc  = 1'b1;
            end
            S_FIN:
            begin
                cmd.emit = stat.out_free;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/tb_operator_precedence_parser.sv @@
`default_nettype none

module tb_operator_precedence_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import opp_pkg::*;

    localparam int N_TERM       = MAX_TERMINALS_DEF;
    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int TOTAL_BEATS  = 1225;
    localparam int QUIET_BEATS  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 64;

    localparam int G_PLUS = 0;
    localparam int G_STAR = 1;
    localparam int G_LPAR = 2;
    localparam int G_RPAR = 3;
    localparam int G_ID   = 4;
    localparam int G_END  = 5;

    class parse_results;
        logic [7:0] stack_mem [DEPTH];
        int         top_idx;
        logic [7:0] term_chars [N_TERM];
        rel_t       rel_tbl [N_TERM][N_TERM];
        int         term_count;
        out_t       pending_results [$];
        int         errors;

        function new();
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            foreach (term_chars[i])
                term_chars[i] = '0;
            foreach (rel_tbl[i, j])
                rel_tbl[i][j] = REL_NONE;
            term_count = 0;
            errors     = 0;
            clear_stack();
        endfunction

        function void clear_stack();
            top_idx      = 0;
            stack_mem[0] = END_MARK;
        endfunction

        function void write_term_count(logic [4:0] value);
            term_count = int'(value);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // highest matching index below term_count wins
        function int find_term(logic [7:0] ch);
            int lim;
            int hit;
            int k;
            lim = (term_count > N_TERM) ? N_TERM : term_count;
            hit = -1;
            for (k = 0; k < lim; k++)
                if (term_chars[k] == ch)
                    hit = k;
            return hit;
        endfunction

        function status_t shift_reduce(logic [7:0] ch, output int reds);
            int   si;
            int   ii;
            rel_t r;
            reds = 0;
            repeat (DEPTH + 2)
            begin
                if (stack_mem[top_idx] == END_MARK && ch == END_MARK)
                    return ST_ACCEPT;
                si = find_term(stack_mem[top_idx]);
                ii = find_term(ch);
                if (si < 0 || ii < 0)
                    return ST_INVALID;
                r = rel_tbl[si][ii];
                if (r == REL_YIELD || r == REL_EQUAL)
                begin
                    if (top_idx + 2 > DEPTH - 1)
                        return ST_OVERFLOW;
                    stack_mem[top_idx + 1] = (r == REL_YIELD) ? YIELD_MARK : EQUAL_MARK;
                    stack_mem[top_idx + 2] = ch;
                    top_idx += 2;
                    return ST_SHIFT;
                end
                if (r != REL_TAKES || top_idx == 0)
                    return ST_REJECT;
                // pop through the nearest yield marker
                while (top_idx > 0 && stack_mem[top_idx] != YIELD_MARK)
                    top_idx--;
                if (top_idx > 0 && stack_mem[top_idx] == YIELD_MARK)
                    top_idx--;
                reds++;
            end
            return ST_REJECT;
        endfunction

        function void predict_beat(in_t beat);
            out_t want;
            int   reds;
            reds        = 0;
            want.status = ST_LOADED;
            case (func_t'(beat.func))
                FUNC_TERM:
                    term_chars[beat.row_index] = beat.char_value;
                FUNC_REL:
                    rel_tbl[beat.row_index][beat.col_index] = rel_t'(beat.relation);
                FUNC_PARSE:
                begin
                    want.status = shift_reduce(beat.char_value, reds);
                    if (want.status != ST_SHIFT)
                        clear_stack();
                end
                default:
                    ;
            endcase
            want.reductions  = (reds > 63) ? RED_MAX : 6'(reds);
            want.stack_level = 7'(top_idx + 1);
            pending_results.push_back(want);
        endfunction

        function void flag(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void compare_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, actual %0d/%0d/%0d",
                         $time, got.status, got.reductions, got.stack_level);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                flag("status", 8'(want.status), 8'(got.status));
            if (got.reductions !== want.reductions)
                flag("reductions", 8'(want.reductions), 8'(got.reductions));
            if (got.stack_level !== want.stack_level)
                flag("stack_level", 8'(want.stack_level), 8'(got.stack_level));
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_write = 1'b0;
    logic [4:0] cfg_data  = '0;

    parse_results results = new();

    logic        idle_en  = 1'b1;
    logic        hold_req = 1'b0;
    logic        grammar_ok;
    int          beats_sent = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  sym_seq [$];
    int          gram_slot [6];
    int          tc_plan [6] = '{16, 31, 0, 6, 17, 11};

    // expression grammar: + * ( ) id end, rows are the stack side
    string gram_syms = "+*()i$";
    string gram_rows [6] = '{"><<><>", ">><><>", "<<<=<.", ">>.>.>", ">>.>.>", "<<<.<."};

    operator_precedence_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            results.compare_result(out_data);

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_operator_precedence_parser failed");
        $finish;
    end

    function automatic rel_t rel_of(byte c);
        case (c)
            "<":     return REL_YIELD;
            "=":     return REL_EQUAL;
            ">":     return REL_TAKES;
            default: return REL_NONE;
        endcase
    endfunction

    function automatic void add_expr(input int depth);
        int pick;
        pick = (depth == 0) ? 0 : $urandom_range(0, 3);
        case (pick)
            0:
                sym_seq.push_back(gram_syms[G_ID]);
            1, 2:
            begin
                add_expr(depth - 1);
                sym_seq.push_back(gram_syms[(pick == 1) ? G_PLUS : G_STAR]);
                add_expr(depth - 1);
            end
            default:
            begin
                sym_seq.push_back(gram_syms[G_LPAR]);
                add_expr(depth - 1);
                sym_seq.push_back(gram_syms[G_RPAR]);
            end
        endcase
    endfunction

    task automatic send_beat(input in_t beat);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        results.predict_beat(beat);
        beats_sent++;
    endtask

    task automatic send_fields(input func_t f, input int row, input int col,
                               input logic [7:0] ch, input rel_t r);
        in_t beat;
        beat.func       = f;
        beat.row_index  = 4'(row);
        beat.col_index  = 4'(col);
        beat.char_value = ch;
        beat.relation   = r;
        send_beat(beat);
    endtask

    task automatic send_parse(input logic [7:0] ch);
        send_fields(FUNC_PARSE, $urandom_range(0, 15), $urandom_range(0, 15), ch,
                    rel_t'($urandom_range(0, 3)));
    endtask

    task automatic set_term_count(input logic [4:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results.outstanding() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        results.write_term_count(value);
    endtask

    task automatic load_grammar(input int tc);
        int         lim;
        int         pool [$];
        int         k;
        int         j;
        int         g;
        logic [7:0] c;
        lim        = (tc > N_TERM) ? N_TERM : tc;
        grammar_ok = (lim >= 6);
        if (!grammar_ok)
        begin
            repeat (3) send_fields(FUNC_TERM, $urandom_range(0, 15), 0, 8'($urandom), REL_NONE);
            return;
        end
        for (k = 0; k < lim; k++)
            pool.push_back(k);
        for (g = 0; g < 6; g++)
        begin
            j = $urandom_range(0, pool.size() - 1);
            gram_slot[g] = pool[j];
            pool.delete(j);
        end
        foreach (pool[i])
        begin
            do
                c = 8'($urandom);
            while (c inside {"+", "*", "(", ")", "i", "$"});
            send_fields(FUNC_TERM, pool[i], $urandom_range(0, 15), c, REL_NONE);
        end
        // a duplicate below its slot loses, one beyond term_count is never seen
        g = $urandom_range(0, 5);
        if (gram_slot[g] > 0)
            send_fields(FUNC_TERM, $urandom_range(0, gram_slot[g] - 1), 0, gram_syms[g], REL_NONE);
        if (lim < N_TERM)
            send_fields(FUNC_TERM, $urandom_range(lim, N_TERM - 1), 0, gram_syms[g], REL_NONE);
        for (g = 0; g < 6; g++)
            send_fields(FUNC_TERM, gram_slot[g], $urandom_range(0, 15), gram_syms[g], REL_NONE);
        for (k = 0; k < 6; k++)
            for (j = 0; j < 6; j++)
                send_fields(FUNC_REL, gram_slot[k], gram_slot[j], 8'($urandom),
                            rel_of(gram_rows[k][j]));
    endtask

    task automatic send_expr();
        int k;
        sym_seq.delete();
        add_expr($urandom_range(0, 4));
        sym_seq.push_back(gram_syms[G_END]);
        if ($urandom_range(0, 4) == 0)
        begin
            k = $urandom_range(0, sym_seq.size() - 1);
            if ($urandom_range(0, 1))
                sym_seq.delete(k);
            else
                sym_seq[k] = gram_syms[$urandom_range(0, 5)];
        end
        foreach (sym_seq[i])
            send_parse(sym_seq[i]);
    endtask

    // nesting of 31 or more runs out of stack
    task automatic send_deep(input int n);
        repeat (n) send_parse(gram_syms[G_LPAR]);
        send_parse(gram_syms[G_ID]);
        repeat (n) send_parse(gram_syms[G_RPAR]);
        send_parse(gram_syms[G_END]);
    endtask

    task automatic send_noise();
        in_t beat;
        int  sel;
        beat = in_t'(20'($urandom));
        sel  = $urandom_range(0, 9);
        if (sel == 0)
            beat.func = FUNC_TERM;
        else if (sel == 1)
            beat.func = FUNC_REL;
        else if (sel < 4)
            beat.func = FUNC_NOP;
        else
        begin
            beat.func = FUNC_PARSE;
            if ($urandom_range(0, 1))
                beat.char_value = gram_syms[$urandom_range(0, 5)];
        end
        send_beat(beat);
    endtask

    task automatic run_directed();
        send_fields(FUNC_PARSE, 0, 0, END_MARK, REL_NONE);
        send_fields(FUNC_PARSE, 15, 15, 8'hFF, REL_TAKES);
        send_fields(FUNC_NOP, 15, 15, 8'hFF, REL_TAKES);
        send_fields(FUNC_TERM, 0, 0, 8'h00, REL_NONE);
        set_term_count(5'd31);
        send_fields(FUNC_TERM, 15, 0, END_MARK, REL_NONE);
        send_fields(FUNC_TERM, 0, 0, "(", REL_NONE);
        send_fields(FUNC_TERM, 9, 0, "(", REL_NONE);
        send_fields(FUNC_TERM, 14, 0, 8'hFF, REL_NONE);
        send_fields(FUNC_REL, 15, 9, 8'h00, REL_YIELD);
        send_fields(FUNC_REL, 9, 9, 8'h00, REL_EQUAL);
        send_fields(FUNC_REL, 9, 14, 8'h00, REL_TAKES);
        send_fields(FUNC_REL, 15, 14, 8'h00, REL_TAKES);
        send_fields(FUNC_REL, 0, 0, 8'hFF, REL_TAKES);
        send_fields(FUNC_REL, 9, 15, 8'h00, REL_NONE);
        // reduce with only the end marker held
        send_parse(8'hFF);
        send_parse("(");
        send_parse("(");
        send_parse(8'hFF);
        send_parse("(");
        send_parse(8'h41);
        send_parse("(");
        send_parse(END_MARK);
        send_parse(END_MARK);
    endtask

    task automatic run_random();
        int phase;
        int tc;
        int phase_end;
        int sel;
        phase = 0;
        while (beats_sent < TOTAL_BEATS)
        begin
            tc = (phase < 6) ? tc_plan[phase] : $urandom_range(0, 31);
            set_term_count(5'(tc));
            load_grammar(tc);
            if (phase == 1)
                hold_req = 1'b1;
            phase_end = beats_sent + (grammar_ok ? 160 : 50);
            if (phase == 0)
                send_deep(31);
            while (beats_sent < phase_end && beats_sent < TOTAL_BEATS)
            begin
                if (beats_sent >= TOTAL_BEATS - QUIET_BEATS)
                    idle_en = 1'b0;
                sel = $urandom_range(0, 19);
                if (!grammar_ok || sel < 4)
                    send_noise();
                else if (sel == 4)
                    send_deep($urandom_range(24, 34));
                else
                    send_expr();
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (results.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results.errors == 0 && results.outstanding() == 0)
            $display("tb_operator_precedence_parser passed");
        else
            $display("tb_operator_precedence_parser failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/opp_pkg.sv
design/opp_ram.sv
design/opp_datapath.sv
design/opp_ctrl.sv
design/operator_precedence_parser.sv
tb/tb_operator_precedence_parser.sv
